[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, disabled while the asynchronous reset is low.
`define U8SD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error(msg);

// Concurrent check that a condition never holds.
`define U8SD_NEVER(lbl, clk_s, rst_s, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
		else $error(msg);

`endif

[src/u8sd_pkg.sv]
`timescale 1ns / 1ps

package u8sd_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int PEND_DEPTH  = 3;

	localparam logic [20:0] REPL_CP    = 21'h00FFFD;
	localparam logic [20:0] MIN_CP_2   = 21'h000080;
	localparam logic [20:0] MIN_CP_3   = 21'h000800;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MIN_CP_4   = 21'h010000;
	localparam logic [20:0] MAX_CP     = 21'h10FFFF;
	localparam logic [20:0] CP_TAB     = 21'h000009;
	localparam logic [20:0] CP_LF      = 21'h00000A;
	localparam logic [20:0] CP_CR      = 21'h00000D;
	localparam logic [20:0] CP_ZWNJ    = 21'h00200C;
	localparam logic [20:0] CP_ZWJ     = 21'h00200D;
	localparam logic [20:0] CP_VS_LO   = 21'h00FE00;
	localparam logic [20:0] CP_VS_HI   = 21'h00FE0F;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_is_final;
	} in_word_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        was_replaced;
		logic        coverage_ignorable;
		logic        text_end;
		logic        text_all_valid;
	} out_word_t;

	typedef out_word_t [MAX_RESULTS-1:0] res_vec_t;

	// Outcome of judging the sequence that starts at one window position.
	typedef struct packed {
		logic        emit;
		logic        stop;
		logic        bad;
		logic [2:0]  used;
		logic [20:0] cp;
	} slot_t;

	function automatic logic [2:0] lead_len(input logic [7:0] lead);
		logic [2:0] len;
		priority if (lead[7] == 1'b0)          len = 3'd1;
		else if (lead[7:5] == 3'b110)          len = 3'd2;
		else if (lead[7:4] == 4'b1110)         len = 3'd3;
		else if (lead[7:3] == 5'b11110)        len = 3'd4;
		else                                   len = 3'd0;
		return len;
	endfunction

	function automatic logic is_ignorable(input logic [20:0] cp);
		return (cp == CP_LF) || (cp == CP_CR) || (cp == CP_TAB) || (cp == CP_ZWNJ) ||
			(cp == CP_ZWJ) || ((cp >= CP_VS_LO) && (cp <= CP_VS_HI));
	endfunction

	// win holds the bytes from the current position upward, first byte lowest.
	function automatic slot_t slot_decode(input logic [31:0] win, input logic [2:0] avail,
		input logic fin);
		slot_t       s;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [2:0]  len;
		logic        cont_ok;
		logic [20:0] v;
		b0 = win[7:0];
		b1 = win[15:8];
		b2 = win[23:16];
		b3 = win[31:24];
		len = lead_len(b0);
		s.emit = 1'b0;
		s.stop = 1'b0;
		s.bad = 1'b1;
		s.used = 3'd1;
		s.cp = REPL_CP;
		v = '0;
		cont_ok = 1'b0;
		priority if (avail == 3'd0) begin
			s.stop = 1'b1;
		end else if ((len != 3'd0) && (len > avail)) begin
			// A short sequence waits for more bytes unless the text ends here.
			if (fin) begin
				s.emit = 1'b1;
			end else begin
				s.stop = 1'b1;
			end
		end else if (len == 3'd1) begin
			s.emit = 1'b1;
			s.bad = 1'b0;
			s.cp = {13'd0, b0};
		end else if (len != 3'd0) begin
			s.emit = 1'b1;
			cont_ok = (b1[7:6] == 2'b10) && ((len < 3'd3) || (b2[7:6] == 2'b10)) &&
				((len < 3'd4) || (b3[7:6] == 2'b10));
			if (cont_ok) begin
				s.used = len;
				priority if (len == 3'd2) begin
					v = {10'd0, b0[4:0], b1[5:0]};
					s.bad = v < MIN_CP_2;
				end else if (len == 3'd3) begin
					v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
					s.bad = (v < MIN_CP_3) || ((v >= SURR_LO) && (v <= SURR_HI));
				end else begin
					v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
					s.bad = (v < MIN_CP_4) || (v > MAX_CP);
				end
				if (!s.bad) begin
					s.cp = v;
				end
			end
		end else begin
			s.emit = 1'b1;
		end
		return s;
	endfunction

endpackage

[src/u8sd_decode.sv]
`timescale 1ns / 1ps

module u8sd_decode (
	input  logic [23:0]       pend_bytes,
	input  logic [1:0]        pend_cnt,
	input  logic              err_seen,
	input  u8sd_pkg::in_word_t word,
	output u8sd_pkg::res_vec_t results,
	output logic [2:0]        res_cnt,
	output logic [23:0]       next_bytes,
	output logic [1:0]        next_cnt,
	output logic              next_err
);

	logic [31:0]      win_w;
	logic [31:0]      rest_w;
	logic [2:0]       n_bytes;
	logic [2:0]       pos;
	logic [2:0]       left;
	logic             live;
	logic             any_bad;
	logic [1:0]       last_idx;
	u8sd_pkg::slot_t  slot [u8sd_pkg::MAX_RESULTS];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (i < int'(pend_cnt)) begin
				win_w[i*8 +: 8] = (i < u8sd_pkg::PEND_DEPTH) ? pend_bytes[(i%3)*8 +: 8] : 8'd0;
			end else if (i == int'(pend_cnt)) begin
				win_w[i*8 +: 8] = word.text_byte;
			end else begin
				win_w[i*8 +: 8] = 8'd0;
			end
		end
	end

	assign n_bytes = {1'b0, pend_cnt} + 3'd1;

	// Sequences are judged one after another; each step moves the position
	// past what the previous one consumed, and the first stall ends the run.
	always_comb begin
		pos = 3'd0;
		live = 1'b1;
		res_cnt = 3'd0;
		any_bad = 1'b0;
		for (int k = 0; k < u8sd_pkg::MAX_RESULTS; k++) begin
			slot[k] = u8sd_pkg::slot_decode(win_w >> {pos, 3'b000}, n_bytes - pos,
				word.byte_is_final);
			if (live && slot[k].emit) begin
				results[k].code_point = slot[k].cp;
				results[k].was_replaced = slot[k].bad;
				results[k].coverage_ignorable = u8sd_pkg::is_ignorable(slot[k].cp);
				results[k].text_end = 1'b0;
				results[k].text_all_valid = 1'b0;
				pos = pos + slot[k].used;
				res_cnt = res_cnt + 3'd1;
				any_bad = any_bad | slot[k].bad;
			end else begin
				live = 1'b0;
				results[k] = '0;
			end
		end
		last_idx = 2'(res_cnt - 3'd1);
		if (word.byte_is_final && (res_cnt != 3'd0)) begin
			results[last_idx].text_end = 1'b1;
			results[last_idx].text_all_valid = !(err_seen || any_bad);
		end
	end

	assign rest_w = win_w >> {pos, 3'b000};
	assign left = n_bytes - pos;
	assign next_bytes = rest_w[23:0];
	assign next_cnt = word.byte_is_final ? 2'd0 : left[1:0];
	assign next_err = word.byte_is_final ? 1'b0 : (err_seen | any_bad);

endmodule

[src/u8sd_out_buf.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8sd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  u8sd_pkg::res_vec_t  results,
	input  logic [2:0]          res_cnt,
	output logic                free,
	output logic                cp_valid,
	input  logic                cp_ready,
	output u8sd_pkg::out_word_t cp_word
);

	u8sd_pkg::res_vec_t res_q;
	logic [2:0]         rem_q;
	logic [1:0]         rd_q;
	logic               pop;

	assign cp_valid = (rem_q != 3'd0);
	assign cp_word = res_q[rd_q];
	assign pop = cp_valid && cp_ready;
	// The buffer can take a new burst in the cycle its last word leaves.
	assign free = (rem_q == 3'd0) || ((rem_q == 3'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			rd_q <= 2'd0;
		end else if (load) begin
			rem_q <= res_cnt;
			rd_q <= 2'd0;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= results;
		end
	end

	`U8SD_NEVER(a_rem_range, clk, arst_n, rem_q > 3'd4, "result count out of range")
	`U8SD_ASSERT(a_load_free, clk, arst_n, load |-> free, "burst loaded over pending words")
	`U8SD_ASSERT(a_load_shows, clk, arst_n, load |=> cp_valid, "loaded burst not presented")

endmodule

[src/utf8_stream_decoder.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Handshake                 Word
// text     text_valid / text_ready   text_word (byte, final flag)
// cp       cp_valid / cp_ready       cp_word (code point and flags)
//
// One byte is taken per cycle while each byte releases at most one code point
// and cp_ready is high. A byte that releases several code points holds the
// input until the result buffer, which drains one word per cycle while
// cp_ready is high, is free again. The first code point is presented once its
// byte, held in the input register, is decoded and loaded into the result buffer.
// Reset clears the valid flags, the pending count and the error flag.

module utf8_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_ready,
	input  u8sd_pkg::in_word_t  text_word,
	output logic                cp_valid,
	input  logic                cp_ready,
	output u8sd_pkg::out_word_t cp_word
);

	u8sd_pkg::in_word_t word_s1;
	logic               valid_s1;
	logic [23:0]        pend_bytes_q;
	logic [1:0]         pend_cnt_q;
	logic               err_q;

	u8sd_pkg::res_vec_t dec_results;
	logic [2:0]         dec_cnt;
	logic [23:0]        dec_bytes;
	logic [1:0]         dec_pend_cnt;
	logic               dec_err;
	logic               ob_free;
	logic               fire;
	logic               load;

	u8sd_decode u_decode (
		.pend_bytes (pend_bytes_q),
		.pend_cnt   (pend_cnt_q),
		.err_seen   (err_q),
		.word       (word_s1),
		.results    (dec_results),
		.res_cnt    (dec_cnt),
		.next_bytes (dec_bytes),
		.next_cnt   (dec_pend_cnt),
		.next_err   (dec_err)
	);

	// A byte that only extends a waiting sequence needs no room downstream.
	assign fire = valid_s1 && ((dec_cnt == 3'd0) || ob_free);
	assign load = fire && (dec_cnt != 3'd0);
	assign text_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			word_s1 <= text_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
			err_q <= 1'b0;
		end else if (fire) begin
			pend_cnt_q <= dec_pend_cnt;
			err_q <= dec_err;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_bytes_q <= dec_bytes;
		end
	end

	u8sd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.results  (dec_results),
		.res_cnt  (dec_cnt),
		.free     (ob_free),
		.cp_valid (cp_valid),
		.cp_ready (cp_ready),
		.cp_word  (cp_word)
	);

	`U8SD_ASSERT(a_final_flush, clk, arst_n, fire && word_s1.byte_is_final |-> dec_cnt != 3'd0, "final byte released no code point")
	`U8SD_ASSERT(a_final_clears, clk, arst_n, fire && word_s1.byte_is_final |=> pend_cnt_q == 2'd0 && !err_q, "text state not cleared at end")

endmodule
